// ----- rtl/core/acm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acm_pkg
// shared constants and codes of the keyword matcher
// ----------------------------------------------------------------------------
package acm_pkg;

    localparam int NODES_DEF    = 1024;
    localparam int ALPHABET_DEF = 128;
    localparam int KEYWORDS_DEF = 256;

    typedef enum logic [2:0] {
        CMD_ADD_CHAR = 3'd0,
        CMD_END_WORD = 3'd1,
        CMD_BUILD    = 3'd2,
        CMD_TEXT     = 3'd3,
        CMD_END_LINE = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_MATCH = 2'd0,
        KIND_LINE  = 2'd1,
        KIND_BUILD = 2'd2,
        KIND_FULL  = 2'd3
    } t_kind;

endpackage

// ----- rtl/core/acm_goto.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acm_goto
// trie transition store with a clearing sweep after reset
// ----------------------------------------------------------------------------
module acm_goto
    import acm_pkg::*;
#(
    parameter int NW = 10,
    parameter int SW = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [NW+SW-1:0]   i_rd_addr,
    output logic [NW-1:0]      o_rd_data,
    input  logic               i_wr_en,
    input  logic [NW+SW-1:0]   i_wr_addr,
    input  logic [NW-1:0]      i_wr_data,
    output logic               o_busy
);

    localparam int DEPTH = 2 ** (NW + SW);

    logic [NW-1:0]    mem [DEPTH];
    logic [NW+SW-1:0] r_clr;
    logic             r_busy;

    // every entry is swept to zero (no child) before the first item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_clr <= r_clr + 1'b1;
            if (r_clr == '1) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            mem[r_clr] <= '0;
        end else if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= mem[i_rd_addr];
    end

    assign o_busy = r_busy;

endmodule

// ----- rtl/core/aho_corasick_matcher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aho_corasick_matcher
// multi-keyword matcher over a trie with failure links
// ----------------------------------------------------------------------------
// input channel i_valid/o_ready carries i_cmd and i_symbol; keyword chars and
// end-keyword words build the trie, a build word computes failure links, text
// chars scan and end-line words close a line. results leave on o_valid/i_ready
// through an output register, so one word is taken while a result waits.
// one word is worked on at a time. keyword char: a goto read, then an insert
// step, plus a result step on a table full result. end keyword and end line:
// taken in idle, plus a step to load any result. text char: a goto read, an
// info read when a child is found, a failure read and goto read per failure
// link followed, plus a result step on a match. build: a pop, a queue read and
// a failure read per queued node, a goto read and check per symbol of each node,
// a walk per non-root child and a failure read and walk per link followed.
// after reset the goto memory is swept to zero, one entry a cycle, over all
// 2**(clog2(NODES)+clog2(ALPHABET)) entries (131072 at the defaults), with
// o_ready low. when the receiver stalls a pending result holds the block
// in its final step until the output register frees.
// ----------------------------------------------------------------------------
module aho_corasick_matcher
    import acm_pkg::*;
#(
    parameter int NODES    = NODES_DEF,
    parameter int ALPHABET = ALPHABET_DEF,
    parameter int KEYWORDS = KEYWORDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_cmd,
    input  logic [6:0]  i_symbol,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_keyword_index,
    output logic [15:0] o_line_number,
    output logic [15:0] o_match_count
);

    localparam int NW   = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int SW   = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int KW_W = $clog2(KEYWORDS + 1);

    typedef enum logic [13:0] {
        ST_CLR     = 14'b00000000000001,
        ST_IDLE    = 14'b00000000000010,
        ST_INS     = 14'b00000000000100,
        ST_SC_GOTO = 14'b00000000001000,
        ST_SC_FAIL = 14'b00000000010000,
        ST_SC_INFO = 14'b00000000100000,
        ST_B_POP   = 14'b00000001000000,
        ST_B_CUR   = 14'b00000010000000,
        ST_B_FC    = 14'b00000100000000,
        ST_B_SYM   = 14'b00001000000000,
        ST_B_CH    = 14'b00010000000000,
        ST_B_WALK  = 14'b00100000000000,
        ST_B_WF    = 14'b01000000000000,
        ST_EMIT    = 14'b10000000000000
    } t_state;

    t_state          r_state, n_state;
    logic [SW-1:0]   r_sym, n_sym;
    logic [NW-1:0]   r_ins_cur, n_ins_cur;
    logic [NW:0]     r_node_cnt, n_node_cnt;
    logic [KW_W-1:0] r_kw_cnt, n_kw_cnt;
    logic [NW-1:0]   r_mc, n_mc;
    logic [15:0]     r_line, n_line;
    logic [15:0]     r_lm, n_lm;
    logic [NW-1:0]   r_p, n_p;
    logic [NW-1:0]   r_c, n_c;
    logic [NW-1:0]   r_cur, n_cur;
    logic [NW-1:0]   r_fcur, n_fcur;
    logic [SW-1:0]   r_bsym, n_bsym;
    logic [NW-1:0]   r_ch, n_ch;
    logic [NW:0]     r_head, n_head;
    logic [NW:0]     r_tail, n_tail;
    t_kind           r_res_kind, n_res_kind;
    logic [7:0]      r_res_kw, n_res_kw;
    logic [15:0]     r_res_line, n_res_line;
    logic [15:0]     r_res_cnt, n_res_cnt;

    logic            out_load;
    logic            in_ready;
    logic            sym_ok;
    logic [SW-1:0]   sym_in;
    logic [15:0]     lm_inc;

    // goto store port
    logic [NW+SW-1:0] goto_ra, goto_wa;
    logic [NW-1:0]    goto_rd, goto_wd;
    logic             goto_we, goto_busy;

    // failure links, node marks and bfs queue
    logic [NW-1:0] fail_mem [NODES];
    logic [8:0]    info_mem [NODES];
    logic [NW-1:0] queue_mem [NODES];

    logic [NW-1:0] fail_ra, fail_wa, fail_wd, fail_rd;
    logic          fail_we;
    logic [NW-1:0] info_ra, info_wa;
    logic [8:0]    info_wd, info_rd;
    logic          info_we;
    logic [NW-1:0] q_ra, q_wa, q_wd, q_rd;
    logic          q_we;

    acm_goto #(
        .NW (NW),
        .SW (SW)
    ) u_goto (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (goto_ra),
        .o_rd_data (goto_rd),
        .i_wr_en   (goto_we),
        .i_wr_addr (goto_wa),
        .i_wr_data (goto_wd),
        .o_busy    (goto_busy)
    );

    always_ff @(posedge i_clk) begin
        if (fail_we) begin
            fail_mem[fail_wa] <= fail_wd;
        end
        fail_rd <= fail_mem[fail_ra];
    end

    always_ff @(posedge i_clk) begin
        if (info_we) begin
            info_mem[info_wa] <= info_wd;
        end
        info_rd <= info_mem[info_ra];
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            queue_mem[q_wa] <= q_wd;
        end
        q_rd <= queue_mem[q_ra];
    end

    assign sym_ok = (32'(i_symbol) < ALPHABET);
    assign sym_in = SW'(i_symbol);
    assign lm_inc = (r_lm != 16'hFFFF) ? r_lm + 16'd1 : r_lm;

    always_comb begin
        n_state    = r_state;
        n_sym      = r_sym;
        n_ins_cur  = r_ins_cur;
        n_node_cnt = r_node_cnt;
        n_kw_cnt   = r_kw_cnt;
        n_mc       = r_mc;
        n_line     = r_line;
        n_lm       = r_lm;
        n_p        = r_p;
        n_c        = r_c;
        n_cur      = r_cur;
        n_fcur     = r_fcur;
        n_bsym     = r_bsym;
        n_ch       = r_ch;
        n_head     = r_head;
        n_tail     = r_tail;
        n_res_kind = r_res_kind;
        n_res_kw   = r_res_kw;
        n_res_line = r_res_line;
        n_res_cnt  = r_res_cnt;
        out_load   = 1'b0;
        in_ready   = 1'b0;
        goto_ra    = '0;
        goto_we    = 1'b0;
        goto_wa    = '0;
        goto_wd    = '0;
        fail_ra    = '0;
        fail_we    = 1'b0;
        fail_wa    = '0;
        fail_wd    = '0;
        info_ra    = '0;
        info_we    = 1'b0;
        info_wa    = '0;
        info_wd    = '0;
        q_ra       = '0;
        q_we       = 1'b0;
        q_wa       = '0;
        q_wd       = '0;

        case (r_state)
            ST_CLR: begin
                if (!goto_busy) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (i_valid) begin
                    n_sym = sym_in;
                    case (i_cmd)
                        CMD_ADD_CHAR: begin
                            if (sym_ok) begin
                                goto_ra = {r_ins_cur, sym_in};
                                n_state = ST_INS;
                            end
                        end
                        CMD_END_WORD: begin
                            n_ins_cur = '0;
                            if (r_ins_cur != '0) begin
                                if (r_kw_cnt >= KW_W'(KEYWORDS)) begin
                                    n_res_kind = KIND_FULL;
                                    n_res_kw   = '0;
                                    n_res_line = r_line;
                                    n_res_cnt  = '0;
                                    n_state    = ST_EMIT;
                                end else begin
                                    info_we  = 1'b1;
                                    info_wa  = r_ins_cur;
                                    info_wd  = {1'b1, 8'(r_kw_cnt)};
                                    n_kw_cnt = r_kw_cnt + 1'b1;
                                end
                            end
                        end
                        CMD_BUILD: begin
                            n_mc    = '0;
                            n_head  = '0;
                            n_tail  = (NW+1)'(1);
                            q_we    = 1'b1;
                            q_wa    = '0;
                            q_wd    = '0;
                            n_state = ST_B_POP;
                        end
                        CMD_TEXT: begin
                            if (sym_ok) begin
                                goto_ra = {r_mc, sym_in};
                                n_p     = r_mc;
                                n_state = ST_SC_GOTO;
                            end else begin
                                n_mc = '0;
                            end
                        end
                        CMD_END_LINE: begin
                            n_res_kind = KIND_LINE;
                            n_res_kw   = '0;
                            n_res_line = r_line;
                            n_res_cnt  = r_lm;
                            n_lm       = '0;
                            n_mc       = '0;
                            if (r_line != 16'hFFFF) begin
                                n_line = r_line + 16'd1;
                            end
                            n_state = ST_EMIT;
                        end
                        default: ;
                    endcase
                end
            end
            ST_INS: begin
                if (goto_rd != '0) begin
                    n_ins_cur = goto_rd;
                    n_state   = ST_IDLE;
                end else if (r_node_cnt >= (NW+1)'(NODES)) begin
                    n_res_kind = KIND_FULL;
                    n_res_kw   = '0;
                    n_res_line = r_line;
                    n_res_cnt  = '0;
                    n_state    = ST_EMIT;
                end else begin
                    // new node starts unmarked
                    goto_we    = 1'b1;
                    goto_wa    = {r_ins_cur, r_sym};
                    goto_wd    = r_node_cnt[NW-1:0];
                    info_we    = 1'b1;
                    info_wa    = r_node_cnt[NW-1:0];
                    info_wd    = '0;
                    n_ins_cur  = r_node_cnt[NW-1:0];
                    n_node_cnt = r_node_cnt + 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_SC_GOTO: begin
                if (goto_rd != '0) begin
                    info_ra = goto_rd;
                    n_c     = goto_rd;
                    n_state = ST_SC_INFO;
                end else if (r_p == '0) begin
                    n_mc    = '0;
                    n_state = ST_IDLE;
                end else begin
                    fail_ra = r_p;
                    n_state = ST_SC_FAIL;
                end
            end
            ST_SC_FAIL: begin
                n_p     = fail_rd;
                goto_ra = {fail_rd, r_sym};
                n_state = ST_SC_GOTO;
            end
            ST_SC_INFO: begin
                if (info_rd[8]) begin
                    n_lm       = lm_inc;
                    n_mc       = '0;
                    n_res_kind = KIND_MATCH;
                    n_res_kw   = info_rd[7:0];
                    n_res_line = r_line;
                    n_res_cnt  = lm_inc;
                    n_state    = ST_EMIT;
                end else begin
                    n_mc    = r_c;
                    n_state = ST_IDLE;
                end
            end
            ST_B_POP: begin
                if (r_head == r_tail) begin
                    n_res_kind = KIND_BUILD;
                    n_res_kw   = '0;
                    n_res_line = r_line;
                    n_res_cnt  = '0;
                    n_state    = ST_EMIT;
                end else begin
                    q_ra    = r_head[NW-1:0];
                    n_head  = r_head + 1'b1;
                    n_state = ST_B_CUR;
                end
            end
            ST_B_CUR: begin
                n_cur   = q_rd;
                fail_ra = q_rd;
                n_state = ST_B_FC;
            end
            ST_B_FC: begin
                n_fcur  = fail_rd;
                n_bsym  = '0;
                n_state = ST_B_SYM;
            end
            ST_B_SYM: begin
                goto_ra = {r_cur, r_bsym};
                n_state = ST_B_CH;
            end
            ST_B_CH: begin
                if (goto_rd == '0) begin
                    if (r_bsym == SW'(ALPHABET - 1)) begin
                        n_state = ST_B_POP;
                    end else begin
                        n_bsym  = r_bsym + 1'b1;
                        n_state = ST_B_SYM;
                    end
                end else if (r_cur == '0) begin
                    // children of the root fail to the root
                    fail_we = 1'b1;
                    fail_wa = goto_rd;
                    fail_wd = '0;
                    q_we    = 1'b1;
                    q_wa    = r_tail[NW-1:0];
                    q_wd    = goto_rd;
                    n_tail  = r_tail + 1'b1;
                    if (r_bsym == SW'(ALPHABET - 1)) begin
                        n_state = ST_B_POP;
                    end else begin
                        n_bsym  = r_bsym + 1'b1;
                        n_state = ST_B_SYM;
                    end
                end else begin
                    n_ch    = goto_rd;
                    n_p     = r_fcur;
                    goto_ra = {r_fcur, r_bsym};
                    n_state = ST_B_WALK;
                end
            end
            ST_B_WALK: begin
                if (goto_rd != '0 || r_p == '0) begin
                    fail_we = 1'b1;
                    fail_wa = r_ch;
                    fail_wd = goto_rd;
                    q_we    = 1'b1;
                    q_wa    = r_tail[NW-1:0];
                    q_wd    = r_ch;
                    n_tail  = r_tail + 1'b1;
                    if (r_bsym == SW'(ALPHABET - 1)) begin
                        n_state = ST_B_POP;
                    end else begin
                        n_bsym  = r_bsym + 1'b1;
                        n_state = ST_B_SYM;
                    end
                end else begin
                    fail_ra = r_p;
                    n_state = ST_B_WF;
                end
            end
            ST_B_WF: begin
                n_p     = fail_rd;
                goto_ra = {fail_rd, r_bsym};
                n_state = ST_B_WALK;
            end
            ST_EMIT: begin
                if (!o_valid || i_ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLR;
            r_ins_cur  <= '0;
            r_node_cnt <= (NW+1)'(1);
            r_kw_cnt   <= '0;
            r_mc       <= '0;
            r_line     <= 16'd1;
            r_lm       <= '0;
            r_head     <= '0;
            r_tail     <= '0;
            o_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ins_cur  <= n_ins_cur;
            r_node_cnt <= n_node_cnt;
            r_kw_cnt   <= n_kw_cnt;
            r_mc       <= n_mc;
            r_line     <= n_line;
            r_lm       <= n_lm;
            r_head     <= n_head;
            r_tail     <= n_tail;
            if (out_load) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym      <= n_sym;
        r_p        <= n_p;
        r_c        <= n_c;
        r_cur      <= n_cur;
        r_fcur     <= n_fcur;
        r_bsym     <= n_bsym;
        r_ch       <= n_ch;
        r_res_kind <= n_res_kind;
        r_res_kw   <= n_res_kw;
        r_res_line <= n_res_line;
        r_res_cnt  <= n_res_cnt;
        if (out_load) begin
            o_kind          <= r_res_kind;
            o_keyword_index <= r_res_kw;
            o_line_number   <= r_res_line;
            o_match_count   <= r_res_cnt;
        end
    end

    assign o_ready = in_ready;

`ifndef SYNTHESIS
    a_node_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_node_cnt <= (NW+1)'(NODES))
        else $error("node count beyond table");

    a_ins_cur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_ins_cur} < r_node_cnt)
        else $error("insert cursor on unallocated node");

    a_match_cur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_mc} < r_node_cnt)
        else $error("match cursor on unallocated node");

    a_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail)
        else $error("bfs queue read past its tail");
`endif

endmodule

// ----- tb/acm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acm_checker
// watches both channels of the keyword matcher, keeps its own copy of the
// trie, failure links and line counters, and compares every result word
// ----------------------------------------------------------------------------
module acm_checker
    import acm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_in_ready,
    input  logic [2:0]  i_cmd,
    input  logic [6:0]  i_symbol,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_keyword_index,
    input  logic [15:0] i_line_number,
    input  logic [15:0] i_match_count,
    output int          o_errors,
    output int          o_pending
);

    localparam int NODES    = NODES_DEF;
    localparam int ALPHABET = ALPHABET_DEF;
    localparam int KEYWORDS = KEYWORDS_DEF;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  kw;
        logic [15:0] line;
        logic [15:0] count;
    } t_result;

    logic [9:0] trie_next [0:NODES*ALPHABET-1];
    logic [9:0] fail_to   [0:NODES-1];
    logic       is_word   [0:NODES-1];
    logic [7:0] word_id   [0:NODES-1];

    int unsigned nodes_used, ins_at, kw_total, scan_at, line_no, line_hits;
    t_result     awaited[$];
    int          errors;

    assign o_errors  = errors;
    assign o_pending = awaited.size();

    initial begin
        for (int i = 0; i < NODES*ALPHABET; i++) trie_next[i] = '0;
        for (int i = 0; i < NODES; i++) begin
            fail_to[i] = '0;
            is_word[i] = 1'b0;
            word_id[i] = '0;
        end
        nodes_used = 1;
        ins_at     = 0;
        kw_total   = 0;
        scan_at    = 0;
        line_no    = 1;
        line_hits  = 0;
        errors     = 0;
    end

    function automatic int unsigned child(int unsigned node, int unsigned sym);
        return trie_next[node*ALPHABET + sym];
    endfunction

    function automatic void push_result(t_kind k, int unsigned kw, int unsigned cnt);
        t_result r;
        r.kind  = k;
        r.kw    = kw[7:0];
        r.line  = line_no[15:0];
        r.count = cnt[15:0];
        awaited.push_back(r);
    endfunction

    // breadth first over the trie, fail links of a level come from the level above
    function automatic void link_failures();
        int unsigned order[$];
        int unsigned cur, ch, tgt, p, steps, c;
        fail_to[0] = '0;
        order.push_back(0);
        while (order.size() > 0) begin
            cur = order.pop_front();
            for (int unsigned s = 0; s < ALPHABET; s++) begin
                ch = child(cur, s);
                if (ch != 0) begin
                    tgt = 0;
                    if (cur != 0) begin
                        p = fail_to[cur];
                        steps = 0;
                        while (steps < NODES) begin
                            c = child(p, s);
                            if (c != 0) begin
                                tgt = c;
                                break;
                            end
                            if (p == 0) break;
                            p = fail_to[p];
                            steps++;
                        end
                    end
                    fail_to[ch] = tgt[9:0];
                    order.push_back(ch);
                end
            end
        end
    endfunction

    function automatic void predict_word(logic [2:0] cmd, logic [6:0] symbol);
        int unsigned sym, ch, node, p, steps, c;
        sym = symbol;
        case (cmd)
            CMD_ADD_CHAR: begin
                ch = child(ins_at, sym);
                if (ch == 0) begin
                    if (nodes_used >= NODES) begin
                        push_result(KIND_FULL, 0, 0);
                        return;
                    end
                    ch = nodes_used++;
                    trie_next[ins_at*ALPHABET + sym] = ch[9:0];
                end
                ins_at = ch;
            end
            CMD_END_WORD: begin
                node = ins_at;
                ins_at = 0;
                if (node != 0) begin
                    if (kw_total >= KEYWORDS) begin
                        push_result(KIND_FULL, 0, 0);
                    end else begin
                        is_word[node] = 1'b1;
                        word_id[node] = kw_total[7:0];
                        kw_total++;
                    end
                end
            end
            CMD_BUILD: begin
                link_failures();
                scan_at = 0;
                push_result(KIND_BUILD, 0, 0);
            end
            CMD_TEXT: begin
                p = scan_at;
                steps = 0;
                while (child(p, sym) == 0 && p != 0 && steps < NODES) begin
                    p = fail_to[p];
                    steps++;
                end
                c = child(p, sym);
                if (c == 0) begin
                    scan_at = 0;
                end else if (is_word[c]) begin
                    if (line_hits < 16'hFFFF) line_hits++;
                    scan_at = 0;
                    push_result(KIND_MATCH, word_id[c], line_hits);
                end else begin
                    scan_at = c;
                end
            end
            CMD_END_LINE: begin
                push_result(KIND_LINE, 0, line_hits);
                line_hits = 0;
                scan_at = 0;
                if (line_no < 16'hFFFF) line_no++;
            end
            default: ;
        endcase
    endfunction

    task automatic report(string what, int unsigned got, int unsigned want);
        $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_result r;
        if (i_rst_n) begin
            if (i_valid && i_in_ready) predict_word(i_cmd, i_symbol);
            if (i_out_valid && i_out_ready) begin
                if (awaited.size() == 0) begin
                    report("unexpected result word, kind", i_kind, 0);
                end else begin
                    r = awaited.pop_front();
                    if (i_kind !== r.kind) report("kind", i_kind, r.kind);
                    if (i_keyword_index !== r.kw) report("keyword index", i_keyword_index, r.kw);
                    if (i_line_number !== r.line) report("line number", i_line_number, r.line);
                    if (i_match_count !== r.count) report("match count", i_match_count, r.count);
                end
            end
        end
    end

endmodule

// ----- tb/tb_aho_corasick_matcher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aho_corasick_matcher
// drives keyword, build, text and end-line words with random gaps and stalls;
// a checker beside the block predicts and compares every result word
// ----------------------------------------------------------------------------
module tb_aho_corasick_matcher;
    import acm_pkg::*;

    localparam int WATCHDOG = 700000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_cmd = '0;
    logic [6:0]  i_symbol = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_keyword_index;
    logic [15:0] o_line_number;
    logic [15:0] o_match_count;

    int errors, pending;
    int words_sent = 0;
    int idle_cycles = 0;
    bit dirty = 1'b0;
    bit steady = 1'b0;
    bit hold_req = 1'b0;

    always #4 i_clk = ~i_clk;

    aho_corasick_matcher i_dut (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_cmd, .i_symbol,
        .o_valid, .i_ready, .o_kind, .o_keyword_index, .o_line_number, .o_match_count
    );

    acm_checker i_chk (
        .i_clk, .i_rst_n, .i_valid, .i_in_ready(o_ready), .i_cmd, .i_symbol,
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_kind(o_kind),
        .i_keyword_index(o_keyword_index), .i_line_number(o_line_number),
        .i_match_count(o_match_count), .o_errors(errors), .o_pending(pending)
    );

    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && ((i_valid && o_ready) || (o_valid && i_ready))) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver side stalls
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    i_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    task automatic send_word(logic [2:0] cmd, logic [6:0] sym);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_cmd    <= cmd;
        i_symbol <= sym;
        do @(posedge i_clk); while (!o_ready);
        words_sent++;
        if (cmd == CMD_ADD_CHAR) dirty = 1'b1;
    endtask

    task automatic send_keyword(logic [6:0] syms[$]);
        foreach (syms[i]) send_word(CMD_ADD_CHAR, syms[i]);
        send_word(CMD_END_WORD, '0);
    endtask

    // text is only scanned over a trie whose failure links are current
    task automatic send_text(logic [6:0] sym);
        if (dirty) begin
            send_word(CMD_BUILD, 7'($urandom));
            dirty = 1'b0;
        end
        send_word(CMD_TEXT, sym);
    endtask

    function automatic logic [6:0] rand_sym();
        if ($urandom_range(0, 99) < 80) return 7'($urandom_range(97, 100));
        return 7'($urandom);
    endfunction

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        logic [6:0] kw[$];
        int n;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty keyword, unknown commands, classic keyword set
        send_word(CMD_END_WORD, '0);
        send_word(3'd5, 7'h7F);
        send_word(3'd6, 7'h00);
        send_word(3'd7, 7'h55);
        send_keyword('{104, 101});
        send_keyword('{115, 104, 101});
        send_keyword('{104, 105, 115});
        send_keyword('{104, 101, 114, 115});
        send_keyword('{0, 127});
        send_text(115); send_text(104); send_text(101); send_text(114); send_text(115);
        send_word(CMD_END_LINE, 7'h7F);
        send_text(0); send_text(127); send_text(127); send_text(0);
        send_word(CMD_END_LINE, '0);

        // random: occasional new keywords, then lines of text
        for (int iter = 0; words_sent < 100; iter++) begin
            steady = (iter % 3 == 2);
            if ($urandom_range(0, 99) < 15) begin
                n = $urandom_range(1, 3);
                repeat (n) begin
                    kw.delete();
                    repeat ($urandom_range(1, 4)) kw.push_back(rand_sym());
                    send_keyword(kw);
                end
            end
            if (iter == 0) hold_req = 1'b1;
            repeat ($urandom_range(1, 3)) begin
                repeat ($urandom_range(3, 20)) begin
                    if ($urandom_range(0, 99) < 4) send_word(3'($urandom_range(5, 7)), rand_sym());
                    else send_text(rand_sym());
                end
                send_word(CMD_END_LINE, rand_sym());
            end
            if ($urandom_range(0, 99) < 3) send_word(CMD_END_WORD, '0);
        end
        steady = 1'b0;
        wait_drained();

        // keyword table overflow with distinct four-letter keywords that also fill nodes
        for (int i = 0; i < 256; i++) begin
            kw.delete();
            kw.push_back(7'(i));
            kw.push_back(7'(i >> 7));
            kw.push_back(7'(i + 1));
            kw.push_back(7'(i + 2));
            send_keyword(kw);
        end
        // node table overflow along a long chain
        repeat (180) send_word(CMD_ADD_CHAR, 7'h7F);
        send_word(CMD_END_WORD, '0);

        wait_drained();
        repeat (50) @(posedge i_clk);
        if (errors == 0 && pending == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

endmodule
